>>> hw/rtl/cilt_pkg.sv
// Shared constants, types and codes for the compacting id list table.
package cilt_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned OUT_CNT_W = 9;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [ID_W-1:0] MARKER_RESET = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // load the request registers
    logic execute;  // perform the operation on the list
  } ctrl_cmd_t;

endpackage

>>> hw/rtl/compacting_id_list_table.sv
// Top level of the compacting id list table: controller plus datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------------
//   request  | in_valid_i / in_ready_o  | operation_i, id_value_i, position_i
//   result   | out_valid_o / out_ready_i| status_o, found_o, read_id_o, entry_count_o,
//            |                          | is_full_o
//   config   | cfg_we_i (no wait)       | cfg_wdata_i (empty marker)
//
// Each request is first captured, then in the execute state the whole list
// is compared in parallel and compacted; the result is then held in registers.
// A new request is taken in the same cycle the held result transfers, so the
// block works on one request at a time and takes the next as the result leaves.
// Reset clears the count and restores the all-ones empty marker; slots at or
// beyond the count are never observed, so they need no clearing.
// A stalled result holds the block; requests wait until it transfers.
module compacting_id_list_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [cilt_pkg::ID_W-1:0]       cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      operation_i,
  input  logic [cilt_pkg::ID_W-1:0]       id_value_i,
  input  logic [cilt_pkg::POS_W-1:0]      position_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            status_o,
  output logic                            found_o,
  output logic [cilt_pkg::ID_W-1:0]       read_id_o,
  output logic [cilt_pkg::OUT_CNT_W-1:0]  entry_count_o,
  output logic                            is_full_o
);

  // capture/execute strobes from the sequencer
  cilt_pkg::ctrl_cmd_t cmd;

  // Sequence capture, execution and the result transfer
  cilt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the list, the count, the marker and the result registers
  cilt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .id_value_i    (id_value_i),
    .position_i    (position_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .read_id_o     (read_id_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o)
  );

endmodule

>>> hw/rtl/cilt_ctrl.sv
// Controller state machine: request capture, execution and result handshake.
module cilt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cilt_pkg::ctrl_cmd_t   cmd_o
);

  cilt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cilt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      cilt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = cilt_pkg::ST_EXEC;
        end
      end
      cilt_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = cilt_pkg::ST_DONE;
      end
      cilt_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          // result leaves; take the next request in the same cycle
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = cilt_pkg::ST_EXEC;
          end else begin
            state_d = cilt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cilt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/cilt_dpath.sv
// Datapath: entry registers, parallel compare, compaction shift and result registers.
module cilt_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cilt_pkg::ctrl_cmd_t             cmd_i,
  input  logic                            cfg_we_i,
  input  logic [cilt_pkg::ID_W-1:0]       cfg_wdata_i,
  input  logic [1:0]                      operation_i,
  input  logic [cilt_pkg::ID_W-1:0]       id_value_i,
  input  logic [cilt_pkg::POS_W-1:0]      position_i,
  output logic                            status_o,
  output logic                            found_o,
  output logic [cilt_pkg::ID_W-1:0]       read_id_o,
  output logic [cilt_pkg::OUT_CNT_W-1:0]  entry_count_o,
  output logic                            is_full_o
);

  localparam int unsigned DEPTH = cilt_pkg::DEPTH;
  localparam int unsigned ID_W  = cilt_pkg::ID_W;
  localparam int unsigned CNT_W = cilt_pkg::CNT_W;
  localparam int unsigned IDX_W = cilt_pkg::IDX_W;
  localparam int unsigned POS_W = cilt_pkg::POS_W;

  logic [ID_W-1:0]   marker_q;
  cilt_pkg::op_e     op_q;
  logic [ID_W-1:0]   id_q;
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ID_W-1:0]   entries_q [DEPTH];
  logic [ID_W-1:0]   entries_d [DEPTH];
  logic              status_q, status_d;
  logic              found_q, found_d;
  logic [ID_W-1:0]   read_id_q, read_id_d;

  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  shift_en;
  logic              any_match;
  logic              id_is_marker;
  logic              is_full;
  logic              add_ok;
  logic              del_ok;
  logic              pos_in_range;
  logic              seen;

  assign id_is_marker = (id_q == marker_q);
  assign is_full      = (count_q == CNT_W'(DEPTH));
  assign pos_in_range = ({{CNT_W{1'b0}}, pos_q} < {{POS_W{1'b0}}, count_q});

  // compare every occupied slot, then mark the first hit and all slots above it
  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      match[k]    = (CNT_W'(k) < count_q) && (entries_q[k] == id_q);
      seen        = seen | match[k];
      shift_en[k] = seen;
    end
  end

  assign any_match = |match;
  assign add_ok    = !is_full && !id_is_marker;
  assign del_ok    = !id_is_marker && any_match;

  always_comb begin
    count_d   = count_q;
    status_d  = 1'b0;
    found_d   = 1'b0;
    read_id_d = '0;
    for (int k = 0; k < DEPTH; k++) begin
      entries_d[k] = entries_q[k];
    end
    unique case (op_q)
      cilt_pkg::OP_ADD: begin
        status_d = !add_ok;
        if (add_ok) begin
          count_d = count_q + CNT_W'(1);
          for (int k = 0; k < DEPTH; k++) begin
            if (count_q == CNT_W'(k)) begin
              entries_d[k] = id_q;
            end
          end
        end
      end
      cilt_pkg::OP_DELETE: begin
        status_d = !del_ok;
        if (del_ok) begin
          count_d = count_q - CNT_W'(1);
          // close the gap: every slot from the hit onward takes its upper neighbor, the freed top slot the marker
          for (int k = 0; k < DEPTH; k++) begin
            if (shift_en[k]) begin
              if (k + 1 < DEPTH) begin
                entries_d[k] = entries_q[(k + 1 < DEPTH) ? k + 1 : k];
              end else begin
                entries_d[k] = marker_q;
              end
            end
            if (count_q == CNT_W'(k + 1)) begin
              entries_d[k] = marker_q;
            end
          end
        end
      end
      cilt_pkg::OP_FIND: begin
        found_d = !id_is_marker && any_match;
      end
      cilt_pkg::OP_READ: begin
        read_id_d = pos_in_range ? entries_q[pos_q[IDX_W-1:0]] : marker_q;
      end
      default: begin
        status_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= cilt_pkg::MARKER_RESET;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      if (cmd_i.execute) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= cilt_pkg::op_e'(operation_i);
      id_q  <= id_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.execute) begin
      status_q  <= status_d;
      found_q   <= found_d;
      read_id_q <= read_id_d;
      for (int k = 0; k < DEPTH; k++) begin
        entries_q[k] <= entries_d[k];
      end
    end
  end

  assign status_o      = status_q;
  assign found_o       = found_q;
  assign read_id_o     = read_id_q;
  assign entry_count_o = cilt_pkg::OUT_CNT_W'(count_q);
  assign is_full_o     = is_full;

endmodule
